>>> hw/rtl/bsb_pkg.sv
// Shared constants, types and helpers for the bounded stack bank.
package bsb_pkg;

   localparam int NUM_STACKS   = 64;
   localparam int MAX_CAPACITY = 16;

   localparam int STACK_W  = $clog2(NUM_STACKS);
   localparam int FILL_W   = $clog2(MAX_CAPACITY + 1);
   localparam int SLOT_W   = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
   localparam int PLATE_N  = NUM_STACKS * MAX_CAPACITY;
   localparam int PLATE_AW = $clog2(PLATE_N);
   localparam int CSR_W    = 5;
   localparam int IDX_W    = 6;
   localparam int VAL_W    = 32;
   localparam int CMP_W    = (CSR_W > FILL_W) ? CSR_W : FILL_W;

   localparam logic [1:0] MODE_PUSH   = 2'd0;
   localparam logic [1:0] MODE_POP    = 2'd1;
   localparam logic [1:0] MODE_POP_AT = 2'd2;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic [VAL_W-1:0] EMPTY_VALUE = '1;

   typedef struct packed {
      logic               push_hit;
      logic [STACK_W-1:0] push_stack;
      logic               pop_hit;
      logic [STACK_W-1:0] pop_stack;
   } pick_type;

   // Out-of-range capacity clamps to 1 .. MAX_CAPACITY.
   function automatic logic [FILL_W-1:0] cap_eff(input logic [CSR_W-1:0] v);
      logic [CMP_W-1:0] w;
      logic [FILL_W-1:0] r;
      w = CMP_W'(v);
      if (w == '0) begin
         r = FILL_W'(1);
      end else if (w > CMP_W'(MAX_CAPACITY)) begin
         r = FILL_W'(MAX_CAPACITY);
      end else begin
         r = FILL_W'(w);
      end
      return r;
   endfunction

   function automatic logic [PLATE_AW-1:0] plate_addr(input logic [STACK_W-1:0] s,
                                                      input logic [SLOT_W-1:0] slot);
      return PLATE_AW'(s) * PLATE_AW'(MAX_CAPACITY) + PLATE_AW'(slot);
   endfunction

endpackage

>>> hw/rtl/bsb_ram.sv
// Single-port synchronous RAM, registered read.
module bsb_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/bsb_select.sv
// Priority encoders over the per-stack full and non-empty flags.
module bsb_select
   import bsb_pkg::*;
(
   input  logic [NUM_STACKS-1:0] nonempty,
   input  logic [NUM_STACKS-1:0] full,
   output pick_type              pick
);

   always_comb begin
      pick = '0;
      // leftmost stack with room
      for (int i = NUM_STACKS - 1; i >= 0; i--) begin
         if (!full[i]) begin
            pick.push_hit   = 1'b1;
            pick.push_stack = STACK_W'(i);
         end
      end
      // rightmost stack holding a plate
      for (int i = 0; i < NUM_STACKS; i++) begin
         if (nonempty[i]) begin
            pick.pop_hit   = 1'b1;
            pick.pop_stack = STACK_W'(i);
         end
      end
   end

endmodule

>>> hw/rtl/bounded_stack_bank.sv
// Bounded stack bank: top level with request sequencer and flag registers.
// One request is in flight at a time. A push, a refused push or an empty pop
// has its result registered after the fill memory read, a pop that finds a
// plate after the fill and then the plate memory read. A result waits while
// the response side still holds the last one. The next request is taken as
// soon as the result is registered, while that result may still wait on the
// response side. After a capacity write the block re-derives its full flags
// from the fill memory, one stack a cycle, and takes no request until that sweep ends.
module bounded_stack_bank
   import bsb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // push_value[31:0], stack_index[37:32], zero
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // popped_value[31:0]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_wdata    // stack_capacity
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_FILL  = 4'b0010,
      S_PLATE = 4'b0100,
      S_SWEEP = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [1:0]             op_ff, op_in;
   logic [VAL_W-1:0]       value_ff, value_in;
   logic [STACK_W-1:0]     stack_ff, stack_in;
   logic                   hit_ff, hit_in;
   logic [NUM_STACKS-1:0]  nonempty_ff, nonempty_in;
   logic [NUM_STACKS-1:0]  full_ff, full_in;
   logic [FILL_W-1:0]      cap_ff, cap_in;
   logic [STACK_W:0]       sweep_ff, sweep_in;
   logic                   pend_ff, pend_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]       rsp_value_ff, rsp_value_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;

   pick_type               pick;
   logic                   req_xfer, csr_xfer, go, is_pop, rsp_load;
   logic [1:0]             req_mode;
   logic [IDX_W-1:0]       req_idx;
   logic                   acc_hit;
   logic [STACK_W-1:0]     acc_stack;

   logic                   fill_we, fill_re;
   logic [STACK_W-1:0]     fill_addr;
   logic [FILL_W-1:0]      fill_wdata, fill_rdata, fill_cur, fill_up, fill_down;
   logic                   plate_we, plate_re;
   logic [PLATE_AW-1:0]    plate_addr_w;
   logic [VAL_W-1:0]       plate_rdata;

   bsb_select u_select (
      .nonempty (nonempty_ff),
      .full     (full_ff),
      .pick     (pick)
   );

   bsb_ram #(.DEPTH(NUM_STACKS), .WIDTH(FILL_W)) u_fill_ram (
      .clock (clock),
      .we    (fill_we),
      .re    (fill_re),
      .addr  (fill_addr),
      .wdata (fill_wdata),
      .rdata (fill_rdata)
   );

   bsb_ram #(.DEPTH(PLATE_N), .WIDTH(VAL_W)) u_plate_ram (
      .clock (clock),
      .we    (plate_we),
      .re    (plate_re),
      .addr  (plate_addr_w),
      .wdata (value_ff),
      .rdata (plate_rdata)
   );

   assign req_mode   = req_tuser;
   assign req_idx    = req_tdata[37:32];
   assign csr_ready  = (state_ff == S_IDLE) || (state_ff == S_SWEEP);
   assign req_tready = (state_ff == S_IDLE) && !csr_valid;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_xfer   = csr_valid && csr_ready;
   assign go         = !rsp_valid_ff || rsp_tready;

   // unwritten fill entries read as empty
   assign fill_cur  = nonempty_ff[stack_ff] ? fill_rdata : '0;
   assign fill_up   = fill_cur + FILL_W'(1);
   assign fill_down = fill_cur - FILL_W'(1);
   assign is_pop    = hit_ff && ((op_ff == MODE_POP) || (op_ff == MODE_POP_AT));

   always_comb begin
      case (req_mode)
         MODE_PUSH: begin
            acc_hit   = pick.push_hit;
            acc_stack = pick.push_stack;
         end
         MODE_POP: begin
            acc_hit   = pick.pop_hit;
            acc_stack = pick.pop_stack;
         end
         MODE_POP_AT: begin
            acc_stack = STACK_W'(req_idx);
            acc_hit   = (int'(req_idx) < NUM_STACKS) && nonempty_ff[acc_stack];
         end
         default: begin
            acc_hit   = 1'b0;
            acc_stack = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      stack_in      = stack_ff;
      hit_in        = hit_ff;
      nonempty_in   = nonempty_ff;
      full_in       = full_ff;
      cap_in        = cap_ff;
      sweep_in      = sweep_ff;
      pend_in       = 1'b0;
      rsp_load      = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      fill_we       = 1'b0;
      fill_re       = 1'b0;
      fill_addr     = stack_ff;
      fill_wdata    = fill_up;
      plate_we      = 1'b0;
      plate_re      = 1'b0;
      plate_addr_w  = plate_addr(stack_ff, SLOT_W'(fill_cur));

      if (csr_xfer) begin
         cap_in   = cap_eff(csr_wdata);
         sweep_in = '0;
         state_in = S_SWEEP;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  op_in     = req_mode;
                  value_in  = req_tdata[VAL_W-1:0];
                  stack_in  = acc_stack;
                  hit_in    = acc_hit;
                  fill_re   = 1'b1;
                  fill_addr = acc_stack;
                  state_in  = S_FILL;
               end
            end
            S_FILL: begin
               if (is_pop) begin
                  fill_we               = 1'b1;
                  fill_wdata            = fill_down;
                  nonempty_in[stack_ff] = (fill_down != '0);
                  full_in[stack_ff]     = (fill_down >= cap_ff);
                  plate_re              = 1'b1;
                  plate_addr_w          = plate_addr(stack_ff, SLOT_W'(fill_down));
                  state_in              = S_PLATE;
               end else if (go) begin
                  rsp_load = 1'b1;
                  state_in = S_IDLE;
                  if (hit_ff) begin
                     fill_we               = 1'b1;
                     plate_we              = 1'b1;
                     nonempty_in[stack_ff] = 1'b1;
                     full_in[stack_ff]     = (fill_up >= cap_ff);
                     rsp_value_in          = '0;
                     rsp_status_in         = ST_DONE;
                  end else begin
                     case (op_ff)
                        MODE_PUSH: begin
                           rsp_value_in  = '0;
                           rsp_status_in = ST_FULL;
                        end
                        MODE_POP, MODE_POP_AT: begin
                           rsp_value_in  = EMPTY_VALUE;
                           rsp_status_in = ST_EMPTY;
                        end
                        default: begin
                           rsp_value_in  = '0;
                           rsp_status_in = ST_DONE;
                        end
                     endcase
                  end
               end
            end
            S_PLATE: begin
               if (go) begin
                  rsp_load      = 1'b1;
                  rsp_value_in  = plate_rdata;
                  rsp_status_in = ST_DONE;
                  state_in      = S_IDLE;
               end
            end
            S_SWEEP: begin
               if (pend_ff) begin
                  full_in[stack_ff] = nonempty_ff[stack_ff] && (fill_cur >= cap_ff);
               end
               if (int'(sweep_ff) < NUM_STACKS) begin
                  fill_re   = 1'b1;
                  fill_addr = STACK_W'(sweep_ff);
                  stack_in  = STACK_W'(sweep_ff);
                  sweep_in  = sweep_ff + (STACK_W + 1)'(1);
                  pend_in   = 1'b1;
               end else if (!pend_ff) begin
                  state_in = S_IDLE;
               end
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hit_ff       <= 1'b0;
         nonempty_ff  <= '0;
         full_ff      <= '0;
         cap_ff       <= FILL_W'(MAX_CAPACITY);
         sweep_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hit_ff       <= hit_in;
         nonempty_ff  <= nonempty_in;
         full_ff      <= full_in;
         cap_ff       <= cap_in;
         sweep_ff     <= sweep_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      value_ff      <= value_in;
      stack_ff      <= stack_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

`ifndef ASSERT_OFF
   a_sweep_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP) |-> (!fill_we && !plate_we))
      else $error("memory write during flag sweep");

   a_pop_to_plate: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FILL) && is_pop && !csr_xfer) |=> (state_ff == S_PLATE))
      else $error("pop did not proceed to plate read");

   a_load_states: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> ((state_ff == S_FILL) || (state_ff == S_PLATE)))
      else $error("result loaded outside a result state");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_we |-> (int'(fill_wdata) <= MAX_CAPACITY))
      else $error("fill count written beyond capacity");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !rsp_load)
      else $error("pending result overwritten");
`endif

endmodule
